// ----- hw/rtl/incremental_pid_deadband_core_assert.svh -----
// Assertion macros shared by the checker files of the incremental PID core.
// Included by bare file name; no other dependencies.
`ifndef INCREMENTAL_PID_DEADBAND_CORE_ASSERT_SVH
`define INCREMENTAL_PID_DEADBAND_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define ICPID_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ICPID_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/icpid_pkg.sv -----
// Shared types and constants of the incremental PID core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package icpid_pkg;

  localparam int TARGET_W   = 16;
  localparam int MEAS_W     = 24;
  localparam int GAIN_W     = 24;
  localparam int DB_W       = 23;
  localparam int LIM_W      = 15;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN   = 3'd0,
    CFG_KI_GAIN   = 3'd1,
    CFG_KD_GAIN   = 3'd2,
    CFG_DEAD_BAND = 3'd3,
    CFG_OUT_LIMIT = 3'd4
  } cfg_idx_e;

  // Per-stage load strobes of the pipeline
  typedef struct packed {
    logic err;
    logic diff;
    logic prod;
    logic inc;
    logic out;
  } pipe_ld_t;

endpackage

`default_nettype wire

// ----- hw/rtl/icpid_if.sv -----
// Valid/ready item channels of the incremental PID core.
// Depends on icpid_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface icpid_in_if import icpid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] target;
  logic signed [MEAS_W-1:0]   measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

interface icpid_out_if import icpid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      in_dead_band;

  modport source (output valid, output drive, output in_dead_band, input ready);
  modport sink   (input valid, input drive, input in_dead_band, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/icpid_front.sv -----
// Error formation, dead band test, error history and difference terms.
// Depends on icpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icpid_front import icpid_pkg::*; #(
  parameter int MEAS_FRAC_BITS = 8,
  localparam int ERR_W = ((TARGET_W + MEAS_FRAC_BITS) > MEAS_W ?
                          (TARGET_W + MEAS_FRAC_BITS) : MEAS_W) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pipe_ld_t                   ld_i,
  input  logic signed [TARGET_W-1:0] target_i,
  input  logic signed [MEAS_W-1:0]   measured_i,
  input  logic        [DB_W-1:0]     dead_band_i,
  output logic signed [ERR_W-1:0]    err_o,
  output logic signed [ERR_W:0]      d1_o,
  output logic signed [ERR_W+1:0]    d2_o,
  output logic                       quiet_o
);

  logic signed [ERR_W-1:0] tgt_ext, meas_ext, err_d, db_ext;
  logic                    quiet_d;
  logic signed [ERR_W-1:0] err1_q;
  logic                    quiet1_q;
  logic signed [ERR_W-1:0] e1_q, e2_q;
  logic signed [ERR_W:0]   d1_d;
  logic signed [ERR_W+1:0] d2_d;

  always_comb begin
    tgt_ext  = ERR_W'(target_i) <<< MEAS_FRAC_BITS;
    meas_ext = ERR_W'(measured_i);
    err_d    = tgt_ext - meas_ext;
    db_ext   = ERR_W'({1'b0, dead_band_i});
    quiet_d  = (err_d <= db_ext) && (err_d >= -db_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.err) begin
      err1_q   <= err_d;
      quiet1_q <= quiet_d;
    end
  end

  // e - e1 and e - 2*e1 + e2 against the history as it stands for this item
  always_comb begin
    d1_d = (ERR_W+1)'(err1_q) - (ERR_W+1)'(e1_q);
    d2_d = (ERR_W+2)'(err1_q) - ((ERR_W+2)'(e1_q) <<< 1) + (ERR_W+2)'(e2_q);
  end

  // History only moves for items outside the dead band
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      e2_q <= '0;
    end else if (ld_i.diff && !quiet1_q) begin
      e2_q <= e1_q;
      e1_q <= err1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.diff) begin
      err_o   <= err1_q;
      d1_o    <= d1_d;
      d2_o    <= d2_d;
      quiet_o <= quiet1_q;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/icpid_mul.sv -----
// Registered gain products for the proportional, integral and derivative terms.
// Depends on icpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icpid_mul import icpid_pkg::*; #(
  parameter int MEAS_FRAC_BITS = 8,
  localparam int ERR_W = ((TARGET_W + MEAS_FRAC_BITS) > MEAS_W ?
                          (TARGET_W + MEAS_FRAC_BITS) : MEAS_W) + 1
) (
  input  logic                           clk_i,
  input  pipe_ld_t                       ld_i,
  input  logic signed [GAIN_W-1:0]       kp_i,
  input  logic signed [GAIN_W-1:0]       ki_i,
  input  logic signed [GAIN_W-1:0]       kd_i,
  input  logic signed [ERR_W-1:0]        err_i,
  input  logic signed [ERR_W:0]          d1_i,
  input  logic signed [ERR_W+1:0]        d2_i,
  input  logic                           quiet_i,
  output logic signed [ERR_W+GAIN_W:0]   pkp_o,
  output logic signed [ERR_W+GAIN_W-1:0] pki_o,
  output logic signed [ERR_W+GAIN_W+1:0] pkd_o,
  output logic                           quiet_o
);

  always_ff @(posedge clk_i) begin
    if (ld_i.prod) begin
      pkp_o   <= kp_i * d1_i;
      pki_o   <= ki_i * err_i;
      pkd_o   <= kd_i * d2_i;
      quiet_o <= quiet_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/icpid_acc.sv -----
// Term sum with truncation toward zero, then the clamped drive accumulator.
// Depends on icpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icpid_acc import icpid_pkg::*; #(
  parameter int MEAS_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS = 16,
  localparam int ERR_W = ((TARGET_W + MEAS_FRAC_BITS) > MEAS_W ?
                          (TARGET_W + MEAS_FRAC_BITS) : MEAS_W) + 1,
  localparam int ACC_W = ERR_W + GAIN_W + 2,
  localparam int SHIFT = MEAS_FRAC_BITS + GAIN_FRAC_BITS,
  localparam int INC_W = ACC_W - SHIFT,
  localparam int SUM_W = (INC_W > DRIVE_W ? INC_W : DRIVE_W) + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pipe_ld_t                       ld_i,
  input  logic signed [ERR_W+GAIN_W:0]   pkp_i,
  input  logic signed [ERR_W+GAIN_W-1:0] pki_i,
  input  logic signed [ERR_W+GAIN_W+1:0] pkd_i,
  input  logic                           quiet_i,
  input  logic        [LIM_W-1:0]        out_limit_i,
  output logic signed [DRIVE_W-1:0]      drive_o,
  output logic                           quiet_o
);

  logic signed [ACC_W-1:0]   sum, bias, biased;
  logic signed [INC_W-1:0]   inc_d, inc_q;
  logic                      quiet4_q;
  logic signed [SUM_W-1:0]   total, lim, clamped;
  logic signed [DRIVE_W-1:0] drive_sum_q;

  // Adding 2^SHIFT-1 to negative sums turns the floor into truncation toward zero
  always_comb begin
    sum    = ACC_W'(pkp_i) + ACC_W'(pki_i) + ACC_W'(pkd_i);
    bias   = ACC_W'({SHIFT{sum[ACC_W-1]}});
    biased = sum + bias;
    inc_d  = quiet_i ? '0 : biased[ACC_W-1:SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.inc) begin
      inc_q    <= inc_d;
      quiet4_q <= quiet_i;
    end
  end

  always_comb begin
    total = SUM_W'(drive_sum_q) + SUM_W'(inc_q);
    lim   = SUM_W'({1'b0, out_limit_i});
    priority if (total >= lim) begin
      clamped = lim;
    end else if (total <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = total;
    end
  end

  // The accumulator doubles as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_sum_q <= '0;
    end else if (ld_i.out) begin
      drive_sum_q <= DRIVE_W'(clamped);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.out) begin
      quiet_o <= quiet4_q;
    end
  end

  assign drive_o = drive_sum_q;

endmodule

`default_nettype wire

// ----- hw/rtl/incremental_pid_deadband_core.sv -----
// Incremental PID controller with dead band: top level, configuration
// registers and pipeline flow control. Depends on icpid_pkg, icpid_if and
// the icpid_front, icpid_mul and icpid_acc stages.
//
// Returns one result per item, in order. Stages are: error and dead band
// test, history update and differences, gain products, term sum with
// truncation, clamped accumulation. Only the accumulator's add-and-clamp
// and the history shift close on themselves, so the sustained rate is one
// item per cycle while the output does not stall. Each stage holds its
// item until the next one is free; input ready drops only when all five
// stages are full and the result is not taken. The user must write gains,
// dead band and limit through the configuration port only while no item
// is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_deadband_core import icpid_pkg::*; #(
  parameter int MEAS_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  icpid_in_if.sink              in_i,
  icpid_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int ERR_W = ((TARGET_W + MEAS_FRAC_BITS) > MEAS_W ?
                          (TARGET_W + MEAS_FRAC_BITS) : MEAS_W) + 1;

  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic        [DB_W-1:0]   dead_band_q;
  logic        [LIM_W-1:0]  out_limit_q;

  logic [5:1] vld_q;
  logic [5:1] rdy;
  pipe_ld_t   ld;

  logic signed [ERR_W-1:0]        err;
  logic signed [ERR_W:0]          d1;
  logic signed [ERR_W+1:0]        d2;
  logic                           quiet2, quiet3;
  logic signed [ERR_W+GAIN_W:0]   pkp;
  logic signed [ERR_W+GAIN_W-1:0] pki;
  logic signed [ERR_W+GAIN_W+1:0] pkd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      dead_band_q <= '0;
      out_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KP_GAIN:   kp_q        <= cfg_wdata_i;
        CFG_KI_GAIN:   ki_q        <= cfg_wdata_i;
        CFG_KD_GAIN:   kd_q        <= cfg_wdata_i;
        CFG_DEAD_BAND: dead_band_q <= cfg_wdata_i[DB_W-1:0];
        CFG_OUT_LIMIT: out_limit_q <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage can take an item when empty or when its own item moves on
  always_comb begin
    rdy[5]   = !vld_q[5] || out_o.ready;
    rdy[4]   = !vld_q[4] || rdy[5];
    rdy[3]   = !vld_q[3] || rdy[4];
    rdy[2]   = !vld_q[2] || rdy[3];
    rdy[1]   = !vld_q[1] || rdy[2];
    ld.err   = in_i.valid && rdy[1];
    ld.diff  = vld_q[1] && rdy[2];
    ld.prod  = vld_q[2] && rdy[3];
    ld.inc   = vld_q[3] && rdy[4];
    ld.out   = vld_q[4] && rdy[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= in_i.valid;
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
      if (rdy[4]) vld_q[4] <= vld_q[3];
      if (rdy[5]) vld_q[5] <= vld_q[4];
    end
  end

  assign in_i.ready  = rdy[1];
  assign out_o.valid = vld_q[5];

  icpid_front #(
    .MEAS_FRAC_BITS(MEAS_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .target_i   (in_i.target),
    .measured_i (in_i.measured),
    .dead_band_i(dead_band_q),
    .err_o      (err),
    .d1_o       (d1),
    .d2_o       (d2),
    .quiet_o    (quiet2)
  );

  icpid_mul #(
    .MEAS_FRAC_BITS(MEAS_FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .kp_i   (kp_q),
    .ki_i   (ki_q),
    .kd_i   (kd_q),
    .err_i  (err),
    .d1_i   (d1),
    .d2_i   (d2),
    .quiet_i(quiet2),
    .pkp_o  (pkp),
    .pki_o  (pki),
    .pkd_o  (pkd),
    .quiet_o(quiet3)
  );

  icpid_acc #(
    .MEAS_FRAC_BITS(MEAS_FRAC_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .pkp_i      (pkp),
    .pki_i      (pki),
    .pkd_i      (pkd),
    .quiet_i    (quiet3),
    .out_limit_i(out_limit_q),
    .drive_o    (out_o.drive),
    .quiet_o    (out_o.in_dead_band)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/icpid_checker.sv -----
// Port-level checks of the incremental PID core, bound to the top level.
// Depends on icpid_pkg and incremental_pid_deadband_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_pid_deadband_core_assert.svh"

module icpid_checker import icpid_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_i
);

  localparam logic signed [DRIVE_W-1:0] DRIVE_MOST_NEG = {1'b1, {(DRIVE_W-1){1'b0}}};

  // A stalled result keeps its value
  `ICPID_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i), "result changed while stalled")

  // The clamp is symmetric, so the most negative code never appears
  `ICPID_ASSERT_RST(a_drive_range, clk_i, rst_ni, out_valid_i |-> drive_i != DRIVE_MOST_NEG, "drive outside clamp range")

  // Input back-pressure only when the pipeline is full behind a stalled result
  `ICPID_ASSERT_RST(a_full_stall, clk_i, rst_ni, in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled with room in pipeline")

  `ICPID_ASSERT_CLK(a_reset_empty, clk_i, !rst_ni |-> !out_valid_i, "result offered during reset")

endmodule

bind incremental_pid_deadband_core icpid_checker u_icpid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .drive_i    (out_o.drive)
);

`default_nettype wire
